>>> rtl/core/winograd_f2x2_3x3_tile_conv_defines.svh
// Assertion macros shared by the Winograd tile convolution RTL
`ifndef WINOGRAD_F2X2_3X3_TILE_CONV_DEFINES_SVH
`define WINOGRAD_F2X2_3X3_TILE_CONV_DEFINES_SVH

// Check an implication on every rising clock edge outside reset
`define WG_ASSERT_IMPL(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("assertion failed");

// Check a condition that must hold even while reset is active
`define WG_ASSERT_ALWAYS(label, clk, cond) \
  label: assert property (@(posedge clk) (cond)) else $error("assertion failed");

`endif

>>> rtl/core/wgc_pkg.sv
// Shared types and constants for the Winograd tile convolution block
package wgc_pkg;
  localparam int unsigned SampleBits = 16;
  localparam int unsigned WeightBits = 16;
  localparam int unsigned AccBits    = 48;
  localparam int unsigned OutBits    = 32;
  localparam int unsigned ShiftBits  = 6;
  localparam int unsigned CfgIdxBits = 1;
  localparam int unsigned CfgBits    = 6;
  localparam int unsigned QueueDepth = 2;

  localparam logic [CfgIdxBits-1:0] CfgResultShift = 1'b0;
  localparam logic [CfgIdxBits-1:0] CfgRoundEnable = 1'b1;

  localparam logic [ShiftBits-1:0] ShiftReset = 6'd14;
endpackage

>>> rtl/core/wgc_front.sv
// Front end: collect tile and kernel rows, form U and V for each channel
module wgc_front #(
  parameter int unsigned SAMPLE_BITS = wgc_pkg::SampleBits,
  parameter int unsigned WEIGHT_BITS = wgc_pkg::WeightBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [3:0][SAMPLE_BITS-1:0]  sample_i,
  input  logic signed [2:0][WEIGHT_BITS-1:0]  weight_i,
  input  logic                                last_i,
  output logic                                tv_valid_o,
  input  logic                                tv_ready_i,
  output logic signed [15:0][WEIGHT_BITS+3:0] u_o,
  output logic signed [15:0][SAMPLE_BITS+3:0] v_o,
  output logic                                last_o
);
  import wgc_pkg::*;
  `include "winograd_f2x2_3x3_tile_conv_defines.svh"

  localparam int unsigned UW = WEIGHT_BITS + 4;
  localparam int unsigned VW = SAMPLE_BITS + 4;

  logic [1:0] row_q, row_d;
  logic signed [SAMPLE_BITS-1:0] tile_q [12];
  logic signed [WEIGHT_BITS-1:0] wt_q [9];
  logic tv_valid_q;
  logic signed [15:0][UW-1:0] u_q, u_d;
  logic signed [15:0][VW-1:0] v_q, v_d;
  logic last_q;
  logic accept;
  logic signed [UW-1:0] g [3][3];
  logic signed [UW-1:0] gg [4][3];
  logic signed [VW-1:0] d [4][4];
  logic signed [VW-1:0] t [4][4];

  assign in_ready_o = !tv_valid_q || tv_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign row_d      = row_q + 2'd1;

  // Form U from the stored kernel rows and V from the stored tile rows plus the current row
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        g[i][j] = UW'(wt_q[i*3+j]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 4; j++) begin
        d[i][j] = VW'(tile_q[i*4+j]);
      end
    end
    for (int j = 0; j < 4; j++) begin
      d[3][j] = VW'($signed(sample_i[j]));
    end
    for (int j = 0; j < 3; j++) begin
      gg[0][j] = g[0][j] <<< 1;
      gg[1][j] = g[0][j] + g[1][j] + g[2][j];
      gg[2][j] = g[0][j] - g[1][j] + g[2][j];
      gg[3][j] = g[2][j] <<< 1;
    end
    for (int i = 0; i < 4; i++) begin
      u_d[i*4+0] = gg[i][0] <<< 1;
      u_d[i*4+1] = gg[i][0] + gg[i][1] + gg[i][2];
      u_d[i*4+2] = gg[i][0] - gg[i][1] + gg[i][2];
      u_d[i*4+3] = gg[i][2] <<< 1;
    end
    for (int j = 0; j < 4; j++) begin
      t[0][j] = d[0][j] - d[2][j];
      t[1][j] = d[1][j] + d[2][j];
      t[2][j] = d[2][j] - d[1][j];
      t[3][j] = d[1][j] - d[3][j];
    end
    for (int i = 0; i < 4; i++) begin
      v_d[i*4+0] = t[i][0] - t[i][2];
      v_d[i*4+1] = t[i][1] + t[i][2];
      v_d[i*4+2] = t[i][2] - t[i][1];
      v_d[i*4+3] = t[i][1] - t[i][3];
    end
  end

  // Advance row counter and output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q      <= 2'd0;
      tv_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        row_q <= row_d;
      end
      if (accept && row_q == 2'd3) begin
        tv_valid_q <= 1'b1;
      end else if (tv_ready_i) begin
        tv_valid_q <= 1'b0;
      end
    end
  end

  // Store rows zero to two, latch transforms on row three
  always_ff @(posedge clk_i) begin
    if (accept && row_q != 2'd3) begin
      for (int j = 0; j < 4; j++) begin
        tile_q[row_q*4+j] <= sample_i[j];
      end
      for (int j = 0; j < 3; j++) begin
        wt_q[row_q*3+j] <= weight_i[j];
      end
    end
    if (accept && row_q == 2'd3) begin
      u_q    <= u_d;
      v_q    <= v_d;
      last_q <= last_i;
    end
  end

  assign tv_valid_o = tv_valid_q;
  assign u_o        = u_q;
  assign v_o        = v_q;
  assign last_o     = last_q;

  `WG_ASSERT_IMPL(a_hold_stall, clk_i, rst_ni,
    (tv_valid_q && !tv_ready_i) |=> tv_valid_q)
  `WG_ASSERT_IMPL(a_row3_load, clk_i, rst_ni,
    (accept && row_q == 2'd3) |=> (tv_valid_q && row_q == 2'd0))
  `WG_ASSERT_ALWAYS(a_ready_stage, clk_i, (!tv_valid_q) |-> in_ready_o)
endmodule

>>> rtl/core/wgc_queue.sv
// Two-entry queue between the transform front and the accumulate back
module wgc_queue #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = wgc_pkg::QueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic [WIDTH-1:0] in_data_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [WIDTH-1:0] out_data_o
);
  import wgc_pkg::*;
  `include "winograd_f2x2_3x3_tile_conv_defines.svh"

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [PW:0] cnt_q;
  logic push, pop;

  assign in_ready_o  = cnt_q != (PW+1)'(DEPTH);
  assign out_valid_o = cnt_q != '0;
  assign push = in_valid_i && in_ready_o;
  assign pop  = out_valid_o && out_ready_i;
  assign out_data_o = mem_q[rd_q];

  // Advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wr_q <= (wr_q == PW'(DEPTH-1)) ? '0 : wr_q + 1'b1;
      if (pop)  rd_q <= (rd_q == PW'(DEPTH-1)) ? '0 : rd_q + 1'b1;
      cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  // Write entry
  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_q] <= in_data_i;
  end

  `WG_ASSERT_IMPL(a_cnt_range, clk_i, rst_ni, cnt_q <= (PW+1)'(DEPTH))
  `WG_ASSERT_IMPL(a_full_hold, clk_i, rst_ni,
    (cnt_q == (PW+1)'(DEPTH) && !out_ready_i) |=> (cnt_q == (PW+1)'(DEPTH)))
  `WG_ASSERT_IMPL(a_push_nonempty, clk_i, rst_ni, push |=> out_valid_o)
endmodule

>>> rtl/core/wgc_back.sv
// Back end: multiply-accumulate, then output transform, round and clamp
module wgc_back #(
  parameter int unsigned SAMPLE_BITS = wgc_pkg::SampleBits,
  parameter int unsigned WEIGHT_BITS = wgc_pkg::WeightBits,
  parameter int unsigned ACC_BITS    = wgc_pkg::AccBits
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [wgc_pkg::ShiftBits-1:0]       shift_i,
  input  logic                                round_i,
  input  logic                                tv_valid_i,
  output logic                                tv_ready_o,
  input  logic signed [15:0][WEIGHT_BITS+3:0] u_i,
  input  logic signed [15:0][SAMPLE_BITS+3:0] v_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [3:0][wgc_pkg::OutBits-1:0] out_o,
  output logic                                sat_o
);
  import wgc_pkg::*;
  `include "winograd_f2x2_3x3_tile_conv_defines.svh"

  localparam int unsigned PW = WEIGHT_BITS + SAMPLE_BITS + 8;

  // Stage 1: products
  logic p_valid_q, p_last_q;
  logic signed [15:0][PW-1:0] prod_q;
  // Stage 2: accumulators and snapshot
  logic signed [15:0][ACC_BITS-1:0] acc_q, acc_d;
  logic signed [15:0][ACC_BITS-1:0] snap_q;
  logic s_valid_q;
  // Stage 3: output transform
  logic signed [3:0][63:0] y_q, y_d;
  logic y_valid_q;
  // Stage 4: result register
  logic o_valid_q;
  logic signed [3:0][OutBits-1:0] out_q;
  logic sat_q;

  logic adv_p, adv_s, adv_y, adv_o;
  logic signed [3:0][63:0] c0, c1;
  logic signed [3:0][OutBits-1:0] res_d;
  logic sat_d;

  // Pipeline flow: stage moves when the next one is free
  assign adv_o = !o_valid_q || out_ready_i;
  assign adv_y = !y_valid_q || adv_o;
  assign adv_s = !s_valid_q || adv_y;
  assign adv_p = adv_s;
  assign tv_ready_o = !p_valid_q || adv_p;

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      acc_d[k] = acc_q[k] + ACC_BITS'($signed(prod_q[k]));
    end
  end

  // Form A^T M A on the snapshot
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      c0[j] = 64'($signed(snap_q[j])) + 64'($signed(snap_q[4+j])) +
              64'($signed(snap_q[8+j]));
      c1[j] = 64'($signed(snap_q[4+j])) - 64'($signed(snap_q[8+j])) -
              64'($signed(snap_q[12+j]));
    end
    y_d[0] = c0[0] + c0[1] + c0[2];
    y_d[1] = c0[1] - c0[2] - c0[3];
    y_d[2] = c1[0] + c1[1] + c1[2];
    y_d[3] = c1[1] - c1[2] - c1[3];
  end

  // Shift, round half up and clamp
  always_comb begin
    logic signed [64:0] r;
    logic signed [63:0] q;
    logic rb;
    sat_d = 1'b0;
    for (int i = 0; i < 4; i++) begin
      q  = $signed(y_q[i]) >>> shift_i;
      rb = (round_i && shift_i != '0) ? y_q[i][shift_i - 1'b1] : 1'b0;
      r  = 65'(q) + 65'(rb);
      if (r > 65'sd2147483647) begin
        res_d[i] = 32'sh7fffffff;
        sat_d    = 1'b1;
      end else if (r < -65'sd2147483648) begin
        res_d[i] = 32'sh80000000;
        sat_d    = 1'b1;
      end else begin
        res_d[i] = r[OutBits-1:0];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
      s_valid_q <= 1'b0;
      y_valid_q <= 1'b0;
      o_valid_q <= 1'b0;
      acc_q     <= '0;
    end else begin
      if (tv_ready_o) p_valid_q <= tv_valid_i;
      if (adv_p && p_valid_q) begin
        acc_q <= p_last_q ? '0 : acc_d;
      end
      if (adv_s) s_valid_q <= p_valid_q && p_last_q;
      if (adv_y) y_valid_q <= s_valid_q;
      if (adv_o) o_valid_q <= y_valid_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (tv_ready_o && tv_valid_i) begin
      for (int k = 0; k < 16; k++) begin
        prod_q[k] <= PW'($signed(u_i[k])) * PW'($signed(v_i[k]));
      end
      p_last_q <= last_i;
    end
    if (adv_s && p_valid_q && p_last_q) snap_q <= acc_d;
    if (adv_y && s_valid_q) y_q <= y_d;
    if (adv_o && y_valid_q) begin
      out_q <= res_d;
      sat_q <= sat_d;
    end
  end

  assign out_valid_o = o_valid_q;
  assign out_o       = out_q;
  assign sat_o       = sat_q;

  `WG_ASSERT_IMPL(a_out_hold, clk_i, rst_ni,
    (o_valid_q && !out_ready_i) |=> (o_valid_q && $stable(out_q)))
  `WG_ASSERT_IMPL(a_clear_last, clk_i, rst_ni,
    (adv_p && p_valid_q && p_last_q) |=> (acc_q == '0))
  `WG_ASSERT_IMPL(a_snap_flow, clk_i, rst_ni,
    (adv_s && p_valid_q && p_last_q) |=> s_valid_q)
endmodule

>>> rtl/core/winograd_f2x2_3x3_tile_conv.sv
// Winograd F(2x2,3x3) tile convolution: one 4x4 tile row per beat, fixed point.
// Rows are taken at one beat per cycle unless a full queue stalls the front end;
// on every fourth row the front end forms U = 4 G g G^T and V = B^T d B and
// hands them through a two-entry queue to the back end, which multiplies sixteen
// pairs, accumulates, and on the last channel forms A^T M A, shifts, rounds and
// clamps through its snapshot, transform and result registers, after the front
// register and the queue. Accumulator and tile stores need no clearing pass;
// the user must write configuration only while idle; the block does not enforce it.
module winograd_f2x2_3x3_tile_conv #(
  parameter int unsigned SAMPLE_BITS = wgc_pkg::SampleBits,
  parameter int unsigned WEIGHT_BITS = wgc_pkg::WeightBits,
  parameter int unsigned ACC_BITS    = wgc_pkg::AccBits
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic cfg_we_i,
  input  logic [wgc_pkg::CfgIdxBits-1:0] cfg_idx_i,
  input  logic [wgc_pkg::CfgBits-1:0]    cfg_data_i,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // sample_0..3 then weight_0..2, SAMPLE_BITS/WEIGHT_BITS each, zero padded to bytes
  input  logic [((4*SAMPLE_BITS+3*WEIGHT_BITS+7)/8)*8-1:0] s_axis_tdata,
  // last_channel
  input  logic s_axis_tuser,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // out_00, out_01, out_10, out_11
  output logic [4*wgc_pkg::OutBits-1:0] m_axis_tdata,
  // saturated
  output logic m_axis_tuser
);
  import wgc_pkg::*;

  localparam int unsigned UW = WEIGHT_BITS + 4;
  localparam int unsigned VW = SAMPLE_BITS + 4;
  localparam int unsigned QW = 16*UW + 16*VW + 1;

  logic [ShiftBits-1:0] shift_q;
  logic round_q;
  logic signed [3:0][SAMPLE_BITS-1:0] smp;
  logic signed [2:0][WEIGHT_BITS-1:0] wgt;
  logic f_valid, f_ready, f_last, b_valid, b_ready;
  logic signed [15:0][UW-1:0] f_u;
  logic signed [15:0][VW-1:0] f_v;
  logic [QW-1:0] q_out;
  logic signed [3:0][OutBits-1:0] res;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q <= ShiftReset;
      round_q <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgResultShift: shift_q <= cfg_data_i[ShiftBits-1:0];
        CfgRoundEnable: round_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Unpack the input beat
  always_comb begin
    for (int j = 0; j < 4; j++) smp[j] = s_axis_tdata[j*SAMPLE_BITS +: SAMPLE_BITS];
    for (int j = 0; j < 3; j++) begin
      wgt[j] = s_axis_tdata[4*SAMPLE_BITS + j*WEIGHT_BITS +: WEIGHT_BITS];
    end
  end

  wgc_front #(.SAMPLE_BITS(SAMPLE_BITS), .WEIGHT_BITS(WEIGHT_BITS)) u_front (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .sample_i(smp), .weight_i(wgt), .last_i(s_axis_tuser),
    .tv_valid_o(f_valid), .tv_ready_i(f_ready),
    .u_o(f_u), .v_o(f_v), .last_o(f_last)
  );

  wgc_queue #(.WIDTH(QW), .DEPTH(QueueDepth)) u_queue (
    .clk_i, .rst_ni,
    .in_valid_i(f_valid), .in_ready_o(f_ready), .in_data_i({f_last, f_v, f_u}),
    .out_valid_o(b_valid), .out_ready_i(b_ready), .out_data_o(q_out)
  );

  wgc_back #(.SAMPLE_BITS(SAMPLE_BITS), .WEIGHT_BITS(WEIGHT_BITS), .ACC_BITS(ACC_BITS))
  u_back (
    .clk_i, .rst_ni, .shift_i(shift_q), .round_i(round_q),
    .tv_valid_i(b_valid), .tv_ready_o(b_ready),
    .u_i(q_out[16*UW-1:0]), .v_i(q_out[16*UW +: 16*VW]), .last_i(q_out[QW-1]),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_o(res), .sat_o(m_axis_tuser)
  );

  assign m_axis_tdata = res;
endmodule
